/* src/column_top_k_select_macros.svh */
// Assertion macros used by the column top-k selector back end.
`ifndef COLUMN_TOP_K_SELECT_MACROS_SVH
`define COLUMN_TOP_K_SELECT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CTKS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ctks assertion failed");

// Next-cycle implication, checked out of reset.
`define CTKS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ctks assertion failed");

`endif

/* src/ctks_pkg.sv */
// Package: types, sizes and register codes of the column top-k selector.
package ctks_pkg;

    localparam int K_MAX      = 16;
    localparam int MAX_ROWS   = 65536;
    localparam int K_W        = $clog2(K_MAX + 1);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int CNT_W      = $clog2(MAX_ROWS + 1);
    localparam int DIST_W     = 32;
    localparam int OUT_ROW_W  = 17;
    localparam int TOPC_W     = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_LARGEST = CFG_IDX_W'(1);

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              column_end;
    } ctks_in_t;

    typedef struct packed {
        logic [DIST_W-1:0]    best_distance;
        logic [OUT_ROW_W-1:0] row_index;
        logic                 last_of_run;
        logic                 overflow;
    } ctks_out_t;

    // One classified request as it sits in the queue.
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [ROW_W-1:0]  row;
        logic              drop;
        logic              column_end;
        logic              overflow;
    } ctks_item_t;

    typedef struct packed {
        logic [K_W-1:0] k;
        logic           select_largest;
    } ctks_cfg_t;

endpackage

/* src/ctks_front.sv */
// Front end: counts rows per column and marks rows past the row limit.
module ctks_front
    import ctks_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ctks_in_t   s_data,
    input  logic       q_full,
    output logic       push,
    output ctks_item_t item
);

    logic [CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic             ovf_reg, ovf_next;
    logic             drop;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;
    assign drop    = row_cnt_reg >= CNT_W'(MAX_ROWS);

    always_comb begin
        item.distance   = s_data.distance;
        item.row        = row_cnt_reg[ROW_W-1:0];
        item.drop       = drop;
        item.column_end = s_data.column_end;
        item.overflow   = ovf_reg || drop;

        row_cnt_next = row_cnt_reg;
        ovf_next     = ovf_reg;
        if (push) begin
            if (s_data.column_end) begin
                row_cnt_next = '0;
                ovf_next     = 1'b0;
            end else begin
                row_cnt_next = drop ? row_cnt_reg : row_cnt_reg + CNT_W'(1);
                ovf_next     = ovf_reg || drop;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            row_cnt_reg <= row_cnt_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

/* src/ctks_queue.sv */
// Small FIFO of classified requests between front and back end.
module ctks_queue
    import ctks_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  ctks_item_t push_item,
    input  logic       pop,
    output ctks_item_t head,
    output logic       full,
    output logic       empty
);

    ctks_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

/* src/ctks_back.sv */
// Back end: shift-insert cells holding the k best, and the result emitter.
`include "column_top_k_select_macros.svh"

module ctks_back
    import ctks_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  ctks_cfg_t  cfg,
    input  ctks_item_t head,
    input  logic       q_empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output ctks_out_t  m_data
);

    localparam logic ST_INSERT = 1'b0;
    localparam logic ST_EMIT   = 1'b1;

    logic              state_reg, state_next;
    logic [DIST_W-1:0] dist_reg [K_MAX];
    logic [DIST_W-1:0] dist_next [K_MAX];
    logic [ROW_W-1:0]  row_reg [K_MAX];
    logic [ROW_W-1:0]  row_next [K_MAX];
    logic [K_W-1:0]    held_reg, held_next;
    logic [K_W-1:0]    remain_reg, remain_next;
    logic              col_ovf_reg, col_ovf_next;
    logic              out_valid_reg, out_valid_next;
    ctks_out_t         out_data_reg, out_data_next;

    logic [K_W-1:0]    held_clip;
    logic [K_MAX-1:0]  hit;
    logic [K_W-1:0]    pos;
    logic              slot_free;
    logic              emit_load;

    assign slot_free = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign pop       = (state_reg == ST_INSERT) && !q_empty;
    assign emit_load = (state_reg == ST_EMIT) && (remain_reg != '0) && slot_free;

    // Parallel compare: a kept entry yields its place when the newcomer ranks strictly ahead.
    always_comb begin
        held_clip = (held_reg > cfg.k) ? cfg.k : held_reg;
        for (int i = 0; i < K_MAX; i++) begin
            hit[i] = (K_W'(i) < held_clip) &&
                     (cfg.select_largest ? (head.distance > dist_reg[i])
                                         : (head.distance < dist_reg[i]));
        end
        pos = held_clip;
        for (int i = K_MAX - 1; i >= 0; i--) begin
            if (hit[i]) begin
                pos = K_W'(i);
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        held_next      = held_reg;
        remain_next    = remain_reg;
        col_ovf_next   = col_ovf_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_ready;
        for (int i = 0; i < K_MAX; i++) begin
            dist_next[i] = dist_reg[i];
            row_next[i]  = row_reg[i];
        end

        case (state_reg)
            ST_INSERT: begin
                if (!q_empty) begin
                    // a dropped row leaves the held count as it is
                    if (!head.drop) begin
                        held_next = held_clip;
                    end
                    if (!head.drop && (pos < cfg.k)) begin
                        if (pos == '0) begin
                            dist_next[0] = head.distance;
                            row_next[0]  = head.row;
                        end
                        for (int i = 1; i < K_MAX; i++) begin
                            if (K_W'(i) == pos) begin
                                dist_next[i] = head.distance;
                                row_next[i]  = head.row;
                            end else if (K_W'(i) > pos) begin
                                dist_next[i] = dist_reg[i-1];
                                row_next[i]  = row_reg[i-1];
                            end
                        end
                        if (held_clip < cfg.k) begin
                            held_next = held_clip + K_W'(1);
                        end
                    end
                    if (head.column_end) begin
                        state_next   = ST_EMIT;
                        remain_next  = head.drop ? held_clip : held_next;
                        col_ovf_next = head.overflow;
                    end
                end
            end
            ST_EMIT: begin
                if (remain_reg == '0) begin
                    held_next  = '0;
                    state_next = ST_INSERT;
                end else if (slot_free) begin
                    out_valid_next              = 1'b1;
                    out_data_next.best_distance = dist_reg[0];
                    out_data_next.row_index     = OUT_ROW_W'(row_reg[0]) + OUT_ROW_W'(1);
                    out_data_next.last_of_run   = remain_reg == K_W'(1);
                    out_data_next.overflow      = col_ovf_reg;
                    remain_next                 = remain_reg - K_W'(1);
                    // rank 0 leaves; the rest move up one place
                    for (int i = 0; i < K_MAX - 1; i++) begin
                        dist_next[i] = dist_reg[i+1];
                        row_next[i]  = row_reg[i+1];
                    end
                end
            end
            default: begin
                state_next = ST_INSERT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < K_MAX; i++) begin
            dist_reg[i] <= dist_next[i];
            row_reg[i]  <= row_next[i];
        end
        out_data_reg <= out_data_next;
        col_ovf_reg  <= col_ovf_next;
        remain_reg   <= remain_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INSERT;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CTKS_ASSERT_NOW(a_held_bound, 1'b1, held_reg <= K_W'(K_MAX))
    `CTKS_ASSERT_NOW(a_pop_only_insert, pop, state_reg == ST_INSERT)
    `CTKS_ASSERT_NOW(a_emit_within_held, (state_reg == ST_EMIT) && (remain_reg != '0), remain_reg <= held_reg)
    `CTKS_ASSERT_NEXT(a_last_drains, emit_load && (remain_reg == K_W'(1)), (state_reg == ST_EMIT) && (remain_reg == '0) && out_valid_reg && out_data_reg.last_of_run)

endmodule

/* src/column_top_k_select.sv */
// Top level of the streaming per-column top-k selector.
//
//  channel | valid     | ready     | payload                     | request
//  --------+-----------+-----------+-----------------------------+-------------------------------
//  input   | s_valid   | s_ready   | s_data    (ctks_in_t)       | one distance, end-of-column bit
//  result  | m_valid   | m_ready   | m_data    (ctks_out_t)      | one ranked distance and row
//  config  | cfg_valid | cfg_ready | cfg_index, cfg_data         | one register write
//
// The back end inserts a non-final request as it pops it; the front end and the
// four-deep queue keep accepting while the back end works or stalls, until the queue is full.
// A column-end request passes through the back end as insert, n results through the
// output register, then clear, with n = min(k, rows kept).
// Output stalls hold the emitter only; the queue absorbs up to four further requests.
// Reset (aresetn low, synchronous) clears counters, queue and held count; k = 1, ascending.
// Kept entries have no reset: only entries below the held count are ever read.
module column_top_k_select
    import ctks_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ctks_in_t              s_data,
    // result requests
    output logic                  m_valid,
    input  logic                  m_ready,
    output ctks_out_t             m_data,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TOPC_W-1:0] top_count_reg;
    logic              select_largest_reg;
    ctks_cfg_t         cfg;

    ctks_item_t        push_item;
    ctks_item_t        head;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;

    // Writes are always taken; the user must send them only while the block is idle, as the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_count_reg      <= TOPC_W'(1);
            select_largest_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TOP_COUNT: begin
                    top_count_reg <= cfg_data[TOPC_W-1:0];
                end
                REG_SELECT_LARGEST: begin
                    select_largest_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective k: register value saturated at the cell count.
    always_comb begin
        if (32'(top_count_reg) > 32'(K_MAX)) begin
            cfg.k = K_W'(K_MAX);
        end else begin
            cfg.k = K_W'(top_count_reg);
        end
        cfg.select_largest = select_largest_reg;
    end

    ctks_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .push    (push),
        .item    (push_item)
    );

    ctks_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    ctks_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
